[hdl/spx_pkg.sv]
// shared types and constants for the sprite run-length pixel expander
package spx_pkg;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    localparam logic [15:0] NEW_ROW_BIT = 16'h8000;
    localparam logic [15:0] SKIP_MASK   = 16'h7fff;

    typedef enum logic [1:0] {
        KIND_START  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_COLOUR = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic        sprite_mode;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        new_row;
        logic [14:0] skip_length;
        logic [15:0] run_length;
        logic [7:0]  colour;
        logic        start_empty;
        logic        header_end;
    } cmd_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  colour;
        logic        valid;
        logic        eos;
    } res_t;

endpackage

[hdl/spx_front.sv]
// front end: accepts input words and classifies them into commands
module spx_front (
    input  logic               push,
    input  logic               full,
    input  logic [1:0]         kind,
    input  logic               sprite_mode,
    input  logic signed [15:0] origin_x,
    input  logic signed [15:0] origin_y,
    input  logic [15:0]        image_width,
    input  logic [15:0]        image_height,
    input  logic               new_row,
    input  logic [14:0]        skip_length,
    input  logic [15:0]        run_length,
    input  logic [7:0]         colour,
    output logic               cmd_push,
    output spx_pkg::cmd_t      cmd
);
    import spx_pkg::*;

    kind_t kind_w;

    assign kind_w = kind_t'(kind);

    always_comb
    begin
        cmd              = '0;
        cmd.kind         = kind_w;
        cmd.sprite_mode  = sprite_mode;
        cmd.origin_x     = origin_x;
        cmd.origin_y     = origin_y;
        cmd.image_width  = image_width;
        cmd.image_height = image_height;
        cmd.new_row      = new_row;
        cmd.skip_length  = skip_length;
        cmd.run_length   = run_length;
        cmd.colour       = colour;
        // opaque start with nothing to draw ends at once
        cmd.start_empty  = !sprite_mode && (image_width == 16'd0 || image_height == 16'd0);
        // header with no row change and no skip, or an empty run, terminates
        cmd.header_end   = (!new_row && skip_length == 15'd0) || run_length == 16'd0;
    end

    // unused kind is dropped here, it never changes state
    always_comb
    begin
        case (kind_w)
            KIND_START, KIND_HEADER, KIND_COLOUR: cmd_push = push && !full;
            default:                              cmd_push = 1'b0;
        endcase
    end

endmodule

[hdl/spx_cmd_queue.sv]
// short command queue between front and back ends
module spx_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  spx_pkg::cmd_t wr_data,
    input  logic          rd_en,
    output logic          rd_valid,
    output spx_pkg::cmd_t rd_data,
    output logic          full
);
    import spx_pkg::*;

    cmd_t                 mem_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg, count_next;
    logic                 do_wr, do_rd;

    assign full     = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_wr && do_rd)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[hdl/spx_back.sv]
// back end: sprite cursor state, pixel generation and result queue
module spx_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  spx_pkg::cmd_t cmd,
    output logic          cmd_pop,
    input  logic          pop,
    output logic          empty,
    output spx_pkg::res_t res
);
    import spx_pkg::*;

    logic        active_reg, active_next;
    logic        transparent_reg, transparent_next;
    logic [15:0] cursor_x_reg, cursor_x_next;
    logic [15:0] cursor_y_reg, cursor_y_next;
    logic [15:0] row_start_x_reg, row_start_x_next;
    logic [15:0] row_width_reg, row_width_next;
    logic [15:0] row_total_reg, row_total_next;
    logic [15:0] column_count_reg, column_count_next;
    logic [15:0] row_count_reg, row_count_next;
    logic [15:0] run_remaining_reg, run_remaining_next;

    // two-entry result queue
    res_t        res_mem_reg [2];
    logic        res_wr_ptr_reg, res_rd_ptr_reg;
    logic [1:0]  res_count_reg, res_count_next;
    logic        res_full;
    logic        res_wr, res_rd;
    res_t        res_w;
    logic        emit;
    logic        go;

    logic [15:0] col_inc, row_inc, hdr_base_x;

    assign res_full = (res_count_reg == 2'd2);
    assign empty    = (res_count_reg == 2'd0);
    assign res      = res_mem_reg[res_rd_ptr_reg];
    assign go       = cmd_valid && !res_full;
    assign cmd_pop  = go;
    assign res_wr   = go && emit;
    assign res_rd   = pop && !empty;

    assign col_inc    = column_count_reg + 16'd1;
    assign row_inc    = row_count_reg + 16'd1;
    assign hdr_base_x = cmd.new_row ? row_start_x_reg : cursor_x_reg;

    always_comb
    begin
        active_next        = active_reg;
        transparent_next   = transparent_reg;
        cursor_x_next      = cursor_x_reg;
        cursor_y_next      = cursor_y_reg;
        row_start_x_next   = row_start_x_reg;
        row_width_next     = row_width_reg;
        row_total_next     = row_total_reg;
        column_count_next  = column_count_reg;
        row_count_next     = row_count_reg;
        run_remaining_next = run_remaining_reg;
        emit               = 1'b0;
        res_w              = '0;

        case (cmd.kind)
            KIND_START:
            begin
                transparent_next   = cmd.sprite_mode;
                cursor_x_next      = cmd.origin_x;
                cursor_y_next      = cmd.origin_y;
                row_start_x_next   = cmd.origin_x;
                row_width_next     = cmd.image_width;
                row_total_next     = cmd.image_height;
                column_count_next  = '0;
                row_count_next     = '0;
                run_remaining_next = '0;
                active_next        = !cmd.start_empty;
                if (cmd.start_empty)
                begin
                    emit      = 1'b1;
                    res_w.eos = 1'b1;
                end
            end
            KIND_HEADER:
            begin
                if (active_reg && transparent_reg)
                begin
                    run_remaining_next = '0;
                    if (cmd.header_end)
                    begin
                        active_next = 1'b0;
                        emit        = 1'b1;
                        res_w.eos   = 1'b1;
                    end
                    else
                    begin
                        cursor_x_next      = hdr_base_x + {1'b0, cmd.skip_length};
                        cursor_y_next      = cmd.new_row ? cursor_y_reg + 16'd1 : cursor_y_reg;
                        run_remaining_next = cmd.run_length;
                    end
                end
            end
            KIND_COLOUR:
            begin
                res_w.x      = cursor_x_reg;
                res_w.y      = cursor_y_reg;
                res_w.colour = cmd.colour;
                res_w.valid  = 1'b1;
                if (active_reg && transparent_reg)
                begin
                    if (run_remaining_reg != 16'd0)
                    begin
                        run_remaining_next = run_remaining_reg - 16'd1;
                        cursor_x_next      = cursor_x_reg + 16'd1;
                        emit               = 1'b1;
                    end
                end
                else if (active_reg)
                begin
                    emit              = 1'b1;
                    column_count_next = col_inc;
                    cursor_x_next     = cursor_x_reg + 16'd1;
                    // end of row: back to the left edge, one row down
                    if (col_inc == row_width_reg)
                    begin
                        column_count_next = '0;
                        cursor_x_next     = row_start_x_reg;
                        cursor_y_next     = cursor_y_reg + 16'd1;
                        row_count_next    = row_inc;
                        if (row_inc == row_total_reg)
                        begin
                            active_next = 1'b0;
                            res_w.eos   = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res_count_next = res_count_reg;
        if (res_wr && !res_rd)
        begin
            res_count_next = res_count_reg + 2'd1;
        end
        else if (!res_wr && res_rd)
        begin
            res_count_next = res_count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg        <= 1'b0;
            transparent_reg   <= 1'b0;
            cursor_x_reg      <= '0;
            cursor_y_reg      <= '0;
            row_start_x_reg   <= '0;
            row_width_reg     <= '0;
            row_total_reg     <= '0;
            column_count_reg  <= '0;
            row_count_reg     <= '0;
            run_remaining_reg <= '0;
            res_wr_ptr_reg    <= 1'b0;
            res_rd_ptr_reg    <= 1'b0;
            res_count_reg     <= '0;
        end
        else
        begin
            if (go)
            begin
                active_reg        <= active_next;
                transparent_reg   <= transparent_next;
                cursor_x_reg      <= cursor_x_next;
                cursor_y_reg      <= cursor_y_next;
                row_start_x_reg   <= row_start_x_next;
                row_width_reg     <= row_width_next;
                row_total_reg     <= row_total_next;
                column_count_reg  <= column_count_next;
                row_count_reg     <= row_count_next;
                run_remaining_reg <= run_remaining_next;
            end
            if (res_wr)
            begin
                res_wr_ptr_reg <= !res_wr_ptr_reg;
            end
            if (res_rd)
            begin
                res_rd_ptr_reg <= !res_rd_ptr_reg;
            end
            res_count_reg <= res_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_wr)
        begin
            res_mem_reg[res_wr_ptr_reg] <= res_w;
        end
    end

endmodule

[hdl/sprite_run_length_pixel_expander.sv]
// Sprite run-length pixel expander, top level. Takes one word per clock when full is low and
// gives at most one result word per input word; a result reaches the ports by way of the command
// queue write of its input word and then one execute step in the back end, which writes it into
// the result queue, and only then can it be popped. The back end carries out one command per
// cycle while the result queue is not full, which sets the sustained rate of one word per cycle;
// the four-deep command queue and two-entry result queue let the input and output sides stall
// independently.
// Non-pixel results (pixel_valid low) are end-of-sprite markers with zero coordinates and colour.
module sprite_run_length_pixel_expander (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         kind,
    input  logic               sprite_mode,
    input  logic signed [15:0] origin_x,
    input  logic signed [15:0] origin_y,
    input  logic [15:0]        image_width,
    input  logic [15:0]        image_height,
    input  logic               new_row,
    input  logic [14:0]        skip_length,
    input  logic [15:0]        run_length,
    input  logic [7:0]         colour,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] pixel_x,
    output logic signed [15:0] pixel_y,
    output logic [7:0]         pixel_colour,
    output logic               pixel_valid,
    output logic               end_of_sprite
);
    import spx_pkg::*;

    cmd_t cmd_in, cmd_out;
    logic cmd_push, cmd_valid, cmd_pop;
    res_t res;

    spx_front u_front (
        .push         (push),
        .full         (full),
        .kind         (kind),
        .sprite_mode  (sprite_mode),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .image_width  (image_width),
        .image_height (image_height),
        .new_row      (new_row),
        .skip_length  (skip_length),
        .run_length   (run_length),
        .colour       (colour),
        .cmd_push     (cmd_push),
        .cmd          (cmd_in)
    );

    spx_cmd_queue u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_push),
        .wr_data  (cmd_in),
        .rd_en    (cmd_pop),
        .rd_valid (cmd_valid),
        .rd_data  (cmd_out),
        .full     (full)
    );

    spx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    assign pixel_x       = $signed(res.x);
    assign pixel_y       = $signed(res.y);
    assign pixel_colour  = res.colour;
    assign pixel_valid   = res.valid;
    assign end_of_sprite = res.eos;

endmodule

[hdl/spx_checker.sv]
// port-level checker for the sprite run-length pixel expander, with its bind
module spx_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic signed [15:0] pixel_x,
    input logic signed [15:0] pixel_y,
    input logic [7:0]         pixel_colour,
    input logic               pixel_valid,
    input logic               end_of_sprite
);

    // queues come out of reset with nothing in them
    a_reset_state: assert property (@(posedge clk) !rst_n |-> (empty && !full))
        else $error("queue status wrong during reset");

    // a non-pixel word is always an end marker with cleared payload
    a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pixel_valid) |->
            (end_of_sprite && pixel_x == 16'sd0 && pixel_y == 16'sd0 && pixel_colour == 8'd0))
        else $error("non-pixel result is not a clean end marker");

    // the input side can only fill up by taking a word
    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a push");

    // a waiting result word holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=>
            (!empty && $stable(pixel_x) && $stable(pixel_y) && $stable(pixel_colour)
             && $stable(pixel_valid) && $stable(end_of_sprite)))
        else $error("waiting result changed");

endmodule

bind sprite_run_length_pixel_expander spx_checker u_spx_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_colour  (pixel_colour),
    .pixel_valid   (pixel_valid),
    .end_of_sprite (end_of_sprite)
);
